// ===== sv/wsm_pkg.sv =====
// Package for the wildcard star pattern matcher: shared constants and types.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps

package wsm_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_START  = 2'd2,
        CMD_FEED   = 2'd3
    } t_cmd;

    // How one sweep over the cells forms the new row.
    typedef enum logic [1:0] {
        MODE_REBUILD = 2'd0,
        MODE_FEED    = 2'd1,
        MODE_HOLD    = 2'd2
    } t_mode;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SWEEP = 1'b1
    } t_state;

endpackage

// ===== sv/wsm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module wsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wildcard_star_pattern_matcher_unit.sv =====
// Top level of the wildcard star pattern matcher: command decode, cell sweep
// sequencer, match row shift register and result register. Uses wsm_pkg, wsm_ram.
`timescale 1ns / 1ps

// Usage. Each input item carries a command (clear pattern, append pattern byte,
// start text, feed text byte) and a byte. Every item yields exactly one result
// item with full_match (the text so far matches the whole pattern) and
// error_flag (append to a full pattern, or a star as the first pattern byte).
// Both channels use valid and stall; an item moves on an edge with valid high
// and stall low.
//
// Timing. The pattern sits in a RAM with a registered read. After an item is
// taken, a sequencer walks cells 0 to PATTERN_MAX, one cell per cycle while
// the walk is not held on its last cell, and shifts the new match row into a
// PATTERN_MAX+1 bit shift register. The result is registered when the walk
// ends; no new item is taken while the walk runs, so the walk over the cells,
// one RAM read per cell, sets the time that an item costs.
//
// Reset clears the pattern length, sets the row to the empty-text row and
// empties the result register; RAM contents stay undefined until written.
// A finished result waits in the output register while the next item is
// already accepted and walked; if the receiver still stalls when that walk
// ends, the walk holds on its last cell until the register frees up.

module wildcard_star_pattern_matcher_unit #(
    parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_full_match,
    output logic       o_error_flag
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int AW = $clog2(PATTERN_MAX);
    localparam logic [LW-1:0] K_LAST = LW'(PATTERN_MAX);
    localparam logic [LW-1:0] K_TWO  = LW'(2);
    localparam logic [LW-1:0] K_ONE  = LW'(1);
    localparam logic [AW-1:0] A_LAST = AW'(PATTERN_MAX - 1);

    wsm_pkg::t_state r_state, n_state;
    wsm_pkg::t_mode  r_mode, n_mode;

    logic [PATTERN_MAX:0] r_row, n_row;
    logic [LW-1:0]        r_len, n_len;
    logic [LW-1:0]        r_k, n_k;
    logic [7:0]           r_byte, n_byte;
    logic [7:0]           r_prev, n_prev;
    logic                 r_err, n_err;
    logic                 r_full, n_full;
    logic                 r_o1, n_o1, r_o2, n_o2;
    logic                 r_n1, n_n1, r_n2, n_n2;
    logic                 r_ovalid, n_ovalid;
    logic                 r_omatch, n_omatch;
    logic                 r_oerr, n_oerr;

    logic                 in_acc;
    logic                 out_free;
    logic                 step;
    logic                 mem_we;
    logic [AW-1:0]        raddr;
    logic [7:0]           rdata;
    logic                 nb;
    logic                 cell_on;
    logic                 byte_hit;
    logic                 prev_hit;
    wsm_pkg::t_cmd        cmd;

    assign cmd      = wsm_pkg::t_cmd'(i_command);
    assign in_acc   = i_in_valid && (r_state == wsm_pkg::ST_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;
    // The last cell step may only run when the result register can take the result.
    assign step     = (r_state == wsm_pkg::ST_SWEEP) && ((r_k != K_LAST) || out_free);
    assign mem_we   = in_acc && (cmd == wsm_pkg::CMD_APPEND) && (r_len != K_LAST);
    // While the walk waits on its last cell the read keeps pointing at the
    // last pattern byte, so the word it needs stays on the RAM output.
    assign raddr    = (r_k == K_LAST) ? A_LAST : r_k[AW-1:0];

    wsm_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_MAX)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_byte_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Step k forms row bit k. The RAM word read in the previous step is
    // pattern byte k-1. Old row bits k-2 and k-1 sit in r_o2 and r_o1, old bit k
    // is at the bottom of the shift register, new bits k-2, k-1 in r_n2, r_n1.
    assign cell_on  = (r_k != '0) && (r_k <= r_len);
    assign byte_hit = (rdata == r_byte) || (rdata == wsm_pkg::DOT_BYTE);
    assign prev_hit = (r_prev == r_byte) || (r_prev == wsm_pkg::DOT_BYTE);

    always_comb begin
        nb = 1'b0;
        case (r_mode)
            wsm_pkg::MODE_REBUILD: begin
                if (r_k == '0) begin
                    nb = 1'b1;
                end else if (cell_on && (rdata == wsm_pkg::STAR_BYTE) && (r_k >= K_TWO)) begin
                    nb = r_n2;
                end
            end
            wsm_pkg::MODE_FEED: begin
                if (cell_on) begin
                    if (rdata == wsm_pkg::STAR_BYTE) begin
                        // A star always quantifies the byte before it; a
                        // leading star has nothing to repeat and stays clear.
                        if (r_k >= K_TWO) begin
                            nb = prev_hit ? (r_n2 | r_o2 | r_row[0]) : r_n2;
                        end
                    end else begin
                        nb = byte_hit & r_o1;
                    end
                end
            end
            wsm_pkg::MODE_HOLD: begin
                nb = r_row[0];
            end
            default: begin
                nb = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_row    = r_row;
        n_len    = r_len;
        n_k      = r_k;
        n_byte   = r_byte;
        n_prev   = r_prev;
        n_err    = r_err;
        n_full   = r_full;
        n_o1     = r_o1;
        n_o2     = r_o2;
        n_n1     = r_n1;
        n_n2     = r_n2;
        n_ovalid = r_ovalid;
        n_omatch = r_omatch;
        n_oerr   = r_oerr;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            wsm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = wsm_pkg::ST_SWEEP;
                    n_k     = '0;
                    n_byte  = i_byte_value;
                    n_err   = 1'b0;
                    n_full  = 1'b0;
                    case (cmd)
                        wsm_pkg::CMD_CLEAR: begin
                            n_len  = '0;
                            n_mode = wsm_pkg::MODE_REBUILD;
                        end
                        wsm_pkg::CMD_APPEND: begin
                            if (r_len == K_LAST) begin
                                n_err  = 1'b1;
                                n_mode = wsm_pkg::MODE_HOLD;
                            end else begin
                                n_err  = (r_len == '0) && (i_byte_value == wsm_pkg::STAR_BYTE);
                                n_len  = r_len + K_ONE;
                                n_mode = wsm_pkg::MODE_REBUILD;
                            end
                        end
                        wsm_pkg::CMD_START: begin
                            n_mode = wsm_pkg::MODE_REBUILD;
                        end
                        default: begin
                            n_mode = wsm_pkg::MODE_FEED;
                        end
                    endcase
                end
            end
            wsm_pkg::ST_SWEEP: begin
                if (step) begin
                    n_row  = {nb, r_row[PATTERN_MAX:1]};
                    n_o2   = r_o1;
                    n_o1   = r_row[0];
                    n_n2   = r_n1;
                    n_n1   = nb;
                    n_prev = rdata;
                    n_k    = r_k + K_ONE;
                    if (r_k == r_len) begin
                        n_full = nb;
                    end
                    if (r_k == K_LAST) begin
                        n_state  = wsm_pkg::ST_IDLE;
                        n_ovalid = 1'b1;
                        n_omatch = (r_k == r_len) ? nb : r_full;
                        n_oerr   = r_err;
                    end
                end
            end
            default: begin
                n_state = wsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wsm_pkg::ST_IDLE;
            r_row    <= (PATTERN_MAX + 1)'(1);
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_k      <= n_k;
        r_byte   <= n_byte;
        r_prev   <= n_prev;
        r_err    <= n_err;
        r_full   <= n_full;
        r_o1     <= n_o1;
        r_o2     <= n_o2;
        r_n1     <= n_n1;
        r_n2     <= n_n2;
        r_omatch <= n_omatch;
        r_oerr   <= n_oerr;
    end

    assign o_in_stall   = (r_state != wsm_pkg::ST_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_full_match = r_omatch;
    assign o_error_flag = r_oerr;

    // A result only appears at the end of a walk over all cells.
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == wsm_pkg::ST_SWEEP && r_k == K_LAST))
        else $error("result appeared without a finished cell walk");

    // A taken item always starts its walk at cell zero.
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == wsm_pkg::ST_SWEEP && r_k == '0))
        else $error("cell walk did not start at cell zero");

    // The pattern length never passes the pattern capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= K_LAST)
        else $error("pattern length exceeds capacity");

    // The RAM is only written between walks, never while cells are read.
    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == wsm_pkg::ST_IDLE))
        else $error("pattern RAM written during a cell walk");

endmodule
